@@ sv/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// clocked assertion on the house clock and reset names
`define ASSERT_RST(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/cgu_pkg.sv @@
// types, constants and the cost scaling function of the certainty grid update
// no dependencies; imported by the interfaces and all modules
package cgu_pkg;

  localparam int unsigned CoordW   = 7;
  localparam int unsigned CostW    = 8;
  localparam int unsigned CertW    = 5;
  localparam int unsigned ProbW    = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned RadSqW   = 14;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_COLUMNS       = 3'd0,
    CFG_GRID_ROWS          = 3'd1,
    CFG_ROBOT_RADIUS_CELLS = 3'd2,
    CFG_FREE_THRESHOLD     = 3'd3,
    CFG_OCCUPIED_THRESHOLD = 3'd4,
    CFG_CERTAINTY_LIMIT    = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]          GridColumnsRst = 8'd100;
  localparam logic [7:0]          GridRowsRst    = 8'd100;
  localparam logic [6:0]          RadiusRst      = 7'd3;
  localparam logic [ProbW-1:0]    FreeThrRst     = 7'd10;
  localparam logic [ProbW-1:0]    OccThrRst      = 7'd50;
  localparam logic [CertW-1:0]    CertLimitRst   = 5'd20;
  localparam logic [CostW-1:0]    CostNoInfo     = 8'hFF;

  // round(cost * 100 / 255), the no-info cost FF counting as 0; the divide by 255
  // uses x/255 = (x + x>>8 + 1) >> 8, exact for x below 65535
  function automatic logic [ProbW-1:0] scale_cost(input logic [CostW-1:0] cost);
    logic [CostW-1:0] c;
    logic [15:0]      x;
    logic [15:0]      q;
    c = (cost == CostNoInfo) ? '0 : cost;
    x = 16'(c) * 16'd100 + 16'd127;
    q = (x + (x >> 8) + 16'd1) >> 8;
    return q[ProbW-1:0];
  endfunction

endpackage

@@ sv/cgu_if.sv @@
// valid/ready channel interfaces for cell items and update results
// depends on cgu_pkg for field widths
interface cgu_in_if import cgu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] cell_column;
  logic [CoordW-1:0] cell_row;
  logic [CostW-1:0]  cost_value;

  modport source (output valid, cell_column, cell_row, cost_value, input ready);
  modport sink   (input valid, cell_column, cell_row, cost_value, output ready);
endinterface

interface cgu_out_if import cgu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CertW-1:0] certainty;
  logic [ProbW-1:0] occupancy_probability;
  logic             inside_robot;

  modport source (output valid, certainty, occupancy_probability, inside_robot,
                  input ready);
  modport sink   (input valid, certainty, occupancy_probability, inside_robot,
                  output ready);
endinterface

@@ sv/cgu_cert_store.sv @@
// certainty store: single-port-write, registered-read memory with a clearing
// sweep after reset; depends on cgu_pkg for the entry width
module cgu_cert_store import cgu_pkg::*; #(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [CertW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [CertW-1:0] wr_data_i,
  output logic             ready_o
);

  logic [CertW-1:0] mem [DEPTH];
  logic [CertW-1:0] rd_data_q;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_busy_q;

endmodule

@@ sv/certainty_grid_cell_update_unit.sv @@
// Certainty grid cell update unit.
// Input channel item_i carries a cell column, row and 8-bit cost; output
// channel result_o returns the cell's new certainty, the scaled occupancy
// probability and an inside-robot flag, one result per item, in order.
// Both channels use valid/ready; a transfer happens when both are high.
// Results go through the middle stage and the output register. Throughput:
// one item per cycle while result_o takes results and the store is not clearing.
// The store is read in the accept cycle and written back as the item leaves
// the middle stage; a back-to-back item on the same cell takes the written
// value through a forwarding register. Reset: configuration returns to its
// defaults and a clearing sweep zeroes all MAX_COLUMNS * MAX_ROWS store
// entries with item_i.ready low; configuration writes are taken throughout.
// Stall: an output register and one middle stage hold results while
// result_o.ready is low; item_i.ready drops once both are full.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no item is in flight; the block itself does not enforce this.
module certainty_grid_cell_update_unit import cgu_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cgu_in_if.sink              item_i,
  cgu_out_if.source           result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration
  logic [7:0]        grid_cols_q, grid_rows_q;
  logic [RadSqW-1:0] rad_sq_q;
  logic [ProbW-1:0]  free_thr_q, occ_thr_q;
  logic [CertW-1:0]  cert_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GridColumnsRst;
      grid_rows_q <= GridRowsRst;
      rad_sq_q    <= RadSqW'(RadiusRst * RadiusRst);
      free_thr_q  <= FreeThrRst;
      occ_thr_q   <= OccThrRst;
      cert_lim_q  <= CertLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_COLUMNS:       grid_cols_q <= cfg_data_i;
        CFG_GRID_ROWS:          grid_rows_q <= cfg_data_i;
        CFG_ROBOT_RADIUS_CELLS: rad_sq_q    <= RadSqW'(cfg_data_i[6:0] * cfg_data_i[6:0]);
        CFG_FREE_THRESHOLD:     free_thr_q  <= cfg_data_i[ProbW-1:0];
        CFG_OCCUPIED_THRESHOLD: occ_thr_q   <= cfg_data_i[ProbW-1:0];
        CFG_CERTAINTY_LIMIT:    cert_lim_q  <= cfg_data_i[CertW-1:0];
        default: ;
      endcase
    end
  end

  // accept stage: address, grid test, squared offsets, probability
  logic              store_ready;
  logic              accept;
  logic              in_grid;
  logic [31:0]       addr_full;
  logic [AW-1:0]     in_addr;
  logic signed [8:0] ctr_col, ctr_row, d_col, d_row;
  logic signed [17:0] sq_col_full, sq_row_full;

  // middle stage
  logic              s1_valid_q;
  logic              s1_in_grid_q;
  logic [AW-1:0]     s1_addr_q;
  logic [ProbW-1:0]  s1_prob_q;
  logic [14:0]       s1_sq_col_q, s1_sq_row_q;
  logic              fwd_hit_q;
  logic [CertW-1:0]  fwd_data_q;
  logic              s1_advance;

  logic [CertW-1:0]  rd_data;
  logic [CertW-1:0]  stored;
  logic [15:0]       dist_sq;
  logic              in_robot;
  logic              do_update;
  logic [CertW:0]    rise_sum;
  logic [CertW-1:0]  cert_new;
  logic [CertW-1:0]  cert_out;

  // output register
  logic              out_valid_q;
  logic [CertW-1:0]  out_cert_q;
  logic [ProbW-1:0]  out_prob_q;
  logic              out_inside_q;

  assign s1_advance   = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = store_ready && (!s1_valid_q || s1_advance);
  assign accept       = item_i.valid && item_i.ready;

  assign in_grid = ({1'b0, item_i.cell_column} < grid_cols_q)
                && ({1'b0, item_i.cell_row} < grid_rows_q)
                && (32'(item_i.cell_column) < MAX_COLUMNS)
                && (32'(item_i.cell_row) < MAX_ROWS);

  assign addr_full = 32'(item_i.cell_column) * 32'(MAX_ROWS) + 32'(item_i.cell_row);
  assign in_addr   = addr_full[AW-1:0];

  // grid centre is size / 2 - 1, which is -1 for a one-cell grid
  assign ctr_col     = $signed({2'b00, grid_cols_q[7:1]}) - 9'sd1;
  assign ctr_row     = $signed({2'b00, grid_rows_q[7:1]}) - 9'sd1;
  assign d_col       = ctr_col - $signed({2'b00, item_i.cell_column});
  assign d_row       = ctr_row - $signed({2'b00, item_i.cell_row});
  assign sq_col_full = d_col * d_col;
  assign sq_row_full = d_row * d_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_in_grid_q <= in_grid;
      s1_addr_q    <= in_addr;
      s1_prob_q    <= scale_cost(item_i.cost_value);
      s1_sq_col_q  <= sq_col_full[14:0];
      s1_sq_row_q  <= sq_row_full[14:0];
      // the memory read misses a write-back to the same cell in this cycle
      fwd_hit_q    <= s1_advance && do_update && (s1_addr_q == in_addr);
      fwd_data_q   <= cert_new;
    end
  end

  cgu_cert_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_grid),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_advance && do_update),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (cert_new),
    .ready_o   (store_ready)
  );

  // read-modify-write of the stored certainty
  assign stored    = fwd_hit_q ? fwd_data_q : rd_data;
  assign dist_sq   = {1'b0, s1_sq_col_q} + {1'b0, s1_sq_row_q};
  assign in_robot  = s1_in_grid_q && (dist_sq <= {2'b00, rad_sq_q});
  assign do_update = s1_in_grid_q && !in_robot;

  always_comb begin
    rise_sum = {1'b0, stored} + ((s1_prob_q <= occ_thr_q) ? (CertW+1)'(1) : (CertW+1)'(2));
    if (s1_prob_q < free_thr_q) begin
      cert_new = (stored == '0) ? '0 : stored - CertW'(1);
    end else if (rise_sum > {1'b0, cert_lim_q}) begin
      cert_new = cert_lim_q;
    end else begin
      cert_new = rise_sum[CertW-1:0];
    end
    if (!s1_in_grid_q) begin
      cert_out = '0;
    end else if (in_robot) begin
      cert_out = stored;
    end else begin
      cert_out = cert_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_cert_q   <= cert_out;
      out_prob_q   <= s1_prob_q;
      out_inside_q <= in_robot;
    end
  end

  assign result_o.valid                 = out_valid_q;
  assign result_o.certainty             = out_cert_q;
  assign result_o.occupancy_probability = out_prob_q;
  assign result_o.inside_robot          = out_inside_q;

  `ASSERT_RST(a_no_accept_while_clearing, accept |-> store_ready,
              "item transfer during store clearing")
  `ASSERT_RST(a_clear_pipe_empty, !store_ready |-> !s1_valid_q && !out_valid_q,
              "pipeline busy during store clearing")
  `ASSERT_RST(a_fwd_in_grid, s1_valid_q && fwd_hit_q |-> s1_in_grid_q,
              "forwarding hit on an item outside the grid")
  `ASSERT_RST(a_advance_fills_out, s1_advance |=> out_valid_q,
              "middle stage advanced without filling the output")

endmodule
